// ===== hdl/dwms_pkg.sv =====
// Shared types and constants of the dive waypoint mission sequencer.
package dwms_pkg;

    // Field widths
    localparam int DEPTH_W    = 16;
    localparam int DWELL_W    = 8;
    localparam int TIMEOUT_W  = 11;
    localparam int DEBRIEF_W  = 9;
    localparam int TICKS_W    = 16;
    localparam int CFG_IDX_W  = 3;

    // Tick limits, one tick being 50 ms
    localparam logic [DWELL_W-1:0]   DWELL_LIMIT   = 8'd160;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_LIMIT = 11'd1200;
    localparam logic [DEBRIEF_W-1:0] DEBRIEF_LIMIT = 9'd400;

    // Register values after reset, millimetres
    localparam logic [DEPTH_W-1:0] FLOOR_RST   = 16'd2000;
    localparam logic [DEPTH_W-1:0] STEP_RST    = 16'd500;
    localparam logic [DEPTH_W-1:0] START_RST   = 16'd500;
    localparam logic [DEPTH_W-1:0] SURFACE_RST = 16'd500;
    localparam logic [DEPTH_W-1:0] BAND_RST    = 16'd125;

    // Input command codes
    typedef enum logic [1:0] {
        CMD_TICK  = 2'd0,
        CMD_START = 2'd1,
        CMD_ABORT = 2'd2
    } t_cmd;

    // Drive command codes
    typedef enum logic [1:0] {
        DRIVE_NONE    = 2'd0,
        DRIVE_DEPTH   = 2'd1,
        DRIVE_SURFACE = 2'd2
    } t_drive;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLOOR   = 3'd0,
        CFG_STEP    = 3'd1,
        CFG_START   = 3'd2,
        CFG_SURFACE = 3'd3,
        CFG_BAND    = 3'd4
    } t_cfg_idx;

    // Configuration register set
    typedef struct packed {
        logic [DEPTH_W-1:0] floor_mm;
        logic [DEPTH_W-1:0] step_mm;
        logic [DEPTH_W-1:0] start_mm;
        logic [DEPTH_W-1:0] surface_mm;
        logic [DEPTH_W-1:0] band_mm;
    } t_cfg;

    // Mission state
    typedef struct packed {
        logic                 active;
        logic                 started;
        logic                 debrief;
        logic                 return_trip;
        logic                 in_mission;
        logic                 success;
        logic [DEPTH_W-1:0]   target;
        logic [DWELL_W-1:0]   dwell;
        logic [TIMEOUT_W-1:0] timeout;
        logic [DEBRIEF_W-1:0] debrief_ticks;
        logic [TICKS_W-1:0]   mission_ticks;
    } t_state;

    // Drive command produced for one item
    typedef struct packed {
        t_drive             drive;
        logic [DEPTH_W-1:0] setpoint;
    } t_result;

endpackage

// ===== hdl/dwms_step.sv =====
// Next-state and drive command logic for one transaction.
module dwms_step
    import dwms_pkg::*;
(
    input  t_cmd               i_cmd,
    input  logic [DEPTH_W-1:0] i_depth,
    input  t_cfg               i_cfg,
    input  t_state             i_state,
    output t_state             o_state,
    output t_result            o_result
);

    // Clamp a signed candidate target into [surface, floor]; floor wins on overlap.
    function automatic logic [DEPTH_W-1:0] clip_target(
        input logic signed [DEPTH_W+1:0] v,
        input logic [DEPTH_W-1:0]        surface,
        input logic [DEPTH_W-1:0]        floor_mm
    );
        logic signed [DEPTH_W+1:0] r;
        r = v;
        if (r < $signed({2'b00, surface})) begin
            r = $signed({2'b00, surface});
        end
        if (r > $signed({2'b00, floor_mm})) begin
            r = $signed({2'b00, floor_mm});
        end
        return r[DEPTH_W-1:0];
    endfunction

    // Ending a mission clears everything but the target and the success flag.
    function automatic t_state f_terminate(input t_state s);
        t_state t;
        t               = s;
        t.active        = 1'b0;
        t.started       = 1'b0;
        t.debrief       = 1'b0;
        t.return_trip   = 1'b0;
        t.in_mission    = 1'b0;
        t.dwell         = '0;
        t.timeout       = '0;
        t.debrief_ticks = '0;
        t.mission_ticks = '0;
        return t;
    endfunction

    // One pass through the mission rules
    always_comb begin
        t_state                    st;
        t_result                   res;
        logic [DEPTH_W-1:0]        err;
        logic signed [DEPTH_W+1:0] cand;
        logic                      done;

        st           = i_state;
        res.drive    = DRIVE_NONE;
        res.setpoint = '0;
        err          = '0;
        cand         = '0;
        done         = 1'b0;

        unique case (i_cmd)
            CMD_START: begin
                st         = f_terminate(st);
                st.success = 1'b0;
                st.target  = clip_target($signed({2'b00, i_cfg.step_mm}),
                                         i_cfg.surface_mm, i_cfg.floor_mm);
                st.active  = 1'b1;
                res.drive  = DRIVE_SURFACE;
            end
            CMD_ABORT: begin
                st        = f_terminate(st);
                res.drive = DRIVE_SURFACE;
            end
            CMD_TICK: begin
                if (st.active && st.debrief) begin
                    // Debrief period: surface until the debrief count runs out.
                    st.in_mission = 1'b0;
                    st.target     = '0;
                    res.drive     = DRIVE_SURFACE;
                    if (st.debrief_ticks >= DEBRIEF_LIMIT) begin
                        st = f_terminate(st);
                    end else if (st.debrief_ticks != '1) begin
                        st.debrief_ticks = st.debrief_ticks + 1'b1;
                    end
                end else if (st.active) begin
                    if (i_depth >= i_cfg.start_mm) begin
                        st.in_mission = 1'b1;
                        st.started    = 1'b1;
                    end
                    if (st.started) begin
                        res.drive    = DRIVE_DEPTH;
                        res.setpoint = st.target;

                        // Dwell counts ticks spent inside the error band.
                        err = (i_depth >= st.target) ? (i_depth - st.target)
                                                     : (st.target - i_depth);
                        if (err <= i_cfg.band_mm) begin
                            if (st.dwell != '1) begin
                                st.dwell = st.dwell + 1'b1;
                            end
                        end else begin
                            st.dwell = '0;
                        end

                        // Waypoint reached: finish, or move on to the next one.
                        if (st.dwell >= DWELL_LIMIT) begin
                            if (st.target <= i_cfg.surface_mm && st.return_trip) begin
                                st.success = 1'b1;
                                st.debrief = 1'b1;
                                done       = 1'b1;
                            end else begin
                                if (st.target == i_cfg.floor_mm) begin
                                    st.return_trip = 1'b1;
                                end
                                st.dwell = '0;
                                if (st.return_trip) begin
                                    cand = $signed({2'b00, st.target})
                                         - $signed({2'b00, i_cfg.step_mm});
                                end else begin
                                    cand = $signed({2'b00, st.target})
                                         + $signed({2'b00, i_cfg.step_mm});
                                end
                                st.target  = clip_target(cand, i_cfg.surface_mm,
                                                         i_cfg.floor_mm);
                                st.timeout = '0;
                            end
                        end

                        // Waypoint held too long: failure debrief.
                        if (!done) begin
                            if (st.timeout >= TIMEOUT_LIMIT) begin
                                st.success = 1'b0;
                                st.debrief = 1'b1;
                            end else begin
                                if (st.mission_ticks != '1) begin
                                    st.mission_ticks = st.mission_ticks + 1'b1;
                                end
                                if (st.timeout != '1) begin
                                    st.timeout = st.timeout + 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            default: begin
            end
        endcase

        o_state  = st;
        o_result = res;
    end

endmodule

// ===== hdl/dive_waypoint_mission_sequencer.sv =====
// Dive waypoint mission sequencer. Each input transaction is a start, abort or
// 50 ms tick command with the measured depth; each gives exactly one output
// transaction with the drive command, the depth setpoint and the mission status.
// One transaction is accepted every clock cycle unless back-pressure holds off
// the input side. Accepting it loads the input register, and the single-pass
// update of the mission state then loads the result register, which offers the
// result. While a result waits for the receiver, the input side takes one more
// transaction into an empty input register and then holds off until the result
// is taken. Configuration writes are always accepted and should only be made
// while no transaction is in flight.
module dive_waypoint_mission_sequencer
    import dwms_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    // Configuration write channel
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DEPTH_W-1:0]   i_cfg_data,

    // Command stream
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [15:0]          s_axis_tdata,  // [15:0] depth_mm
    input  logic [1:0]           s_axis_tuser,  // [1:0] cmd

    // Drive command stream
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [15:0] setpoint_mm, [16] mission_active, [17] in_mission, [18] debriefing,
    // [19] mission_success, [20] returning, [36:21] elapsed_ticks, [39:37] zero
    output logic [39:0]          m_axis_tdata,
    output logic [1:0]           m_axis_tuser   // [1:0] drive_mode
);

    t_cfg               r_cfg;
    t_state             r_state;
    t_state             n_state;
    t_result            step_res;
    logic               r_in_valid;
    t_cmd               r_in_cmd;
    logic [DEPTH_W-1:0] r_in_depth;
    logic               r_out_valid;
    logic [39:0]        r_out_data;
    logic [1:0]         r_out_user;
    logic               out_free;
    logic               advance;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.floor_mm   <= FLOOR_RST;
            r_cfg.step_mm    <= STEP_RST;
            r_cfg.start_mm   <= START_RST;
            r_cfg.surface_mm <= SURFACE_RST;
            r_cfg.band_mm    <= BAND_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_FLOOR:   r_cfg.floor_mm   <= i_cfg_data;
                CFG_STEP:    r_cfg.step_mm    <= i_cfg_data;
                CFG_START:   r_cfg.start_mm   <= i_cfg_data;
                CFG_SURFACE: r_cfg.surface_mm <= i_cfg_data;
                CFG_BAND:    r_cfg.band_mm    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Pipeline flow control
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_cmd   <= t_cmd'(s_axis_tuser);
            r_in_depth <= s_axis_tdata;
        end
    end

    // Mission update
    dwms_step u_step (
        .i_cmd    (r_in_cmd),
        .i_depth  (r_in_depth),
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_user <= step_res.drive;
            r_out_data <= {3'b000,
                           n_state.mission_ticks,
                           n_state.return_trip,
                           n_state.success,
                           n_state.debrief,
                           n_state.in_mission,
                           n_state.active,
                           step_res.setpoint};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule
